// ===== rtl/core/sep2d_pkg.sv =====
// ----------------------------------------------------------------------------
// Separable 2D FIR package
// Shared types and constants for the separable 2D FIR core.
// ----------------------------------------------------------------------------
`default_nettype none

package sep2d_pkg;

  localparam int MaxTaps   = 8;
  localparam int MaxWidth  = 1024;
  localparam int NumLines  = MaxTaps - 1;
  localparam int MemDepth  = NumLines * MaxWidth;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    RegImageWidth = 3'd0,
    RegRowTaps    = 3'd1,
    RegColTaps    = 3'd2,
    RegAddMode    = 3'd3,
    RegRowCoefLo  = 3'd4,
    RegRowCoefHi  = 3'd5,
    RegColCoefLo  = 3'd6,
    RegColCoefHi  = 3'd7
  } reg_idx_e;

  // Cleaned-up configuration as seen by the datapath.
  typedef struct packed {
    logic [10:0]  width;
    logic [2:0]   rt_m1;
    logic [2:0]   ct_m1;
    logic         add_mode;
    logic [127:0] row_coef;
    logic [127:0] col_coef;
  } cfg_t;

  // One classified request handed from front to back.
  // Tap 0 is the current sample, tap k the sample k positions earlier.
  typedef struct packed {
    logic [7:0][15:0] taps;
    logic [31:0]      old_value;
    logic             do_row;
    logic             do_out;
    logic [9:0]       ox;
    logic [11:0]      oy;
    logic [2:0]       line;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } back_stat_t;

  typedef enum logic [3:0] {
    BkIdle,
    BkRowMul,
    BkRowAcc,
    BkRowSat,
    BkColRd,
    BkColMul,
    BkColAcc,
    BkFin
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/sep2d_front.sv =====
// ----------------------------------------------------------------------------
// Separable 2D FIR front end
// Tracks raster position and the sample window, classifies each request.
// ----------------------------------------------------------------------------
`default_nettype none

module sep2d_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sep2d_pkg::cfg_t   cfg_i,
  input  wire logic              acc_i,
  input  wire logic [15:0]       sample_i,
  input  wire logic [31:0]       old_value_i,
  input  wire logic              frame_start_i,
  output      sep2d_pkg::entry_t entry_o
);

  logic [9:0]        pos_x_q, pos_x_d;
  logic [11:0]       pos_y_q, pos_y_d;
  logic [2:0]        line_q, line_d;
  logic [6:0][15:0]  win_q;
  logic [9:0]        cur_x;
  logic [11:0]       cur_y;
  logic [2:0]        cur_line;

  // Position seen by this request, after a frame restart.
  always_comb begin
    cur_x    = frame_start_i ? 10'd0 : pos_x_q;
    cur_y    = frame_start_i ? 12'd0 : pos_y_q;
    cur_line = frame_start_i ? 3'd0 : line_q;

    entry_o.taps[0] = sample_i;
    for (int k = 1; k < 8; k++) begin
      entry_o.taps[k] = win_q[k-1];
    end
    entry_o.old_value = old_value_i;
    entry_o.do_row    = cur_x >= {7'd0, cfg_i.rt_m1};
    entry_o.do_out    = entry_o.do_row && (cur_y >= {9'd0, cfg_i.ct_m1});
    entry_o.ox        = cur_x - {7'd0, cfg_i.rt_m1};
    entry_o.oy        = cur_y - {9'd0, cfg_i.ct_m1};
    entry_o.line      = cur_line;

    // Advance position; the line ring follows the row modulo seven.
    if (({1'b0, cur_x} + 11'd1) >= cfg_i.width) begin
      pos_x_d = 10'd0;
      pos_y_d = cur_y + 12'd1;
      if (cur_y == 12'hFFF || cur_line == 3'd6) begin
        line_d = 3'd0;
      end else begin
        line_d = cur_line + 3'd1;
      end
    end else begin
      pos_x_d = cur_x + 10'd1;
      pos_y_d = cur_y;
      line_d  = cur_line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      line_q  <= '0;
      win_q   <= '0;
    end else if (acc_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      line_q  <= line_d;
      win_q   <= {win_q[5:0], sample_i};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sep2d_queue.sv =====
// ----------------------------------------------------------------------------
// Separable 2D FIR request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sep2d_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sep2d_pkg::entry_t push_data_i,
  input  wire logic              pop_i,
  output      sep2d_pkg::entry_t pop_data_o,
  output      sep2d_pkg::q_stat_t stat_o
);

  sep2d_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign stat_o.full  = count_q == 2'd2;
  assign stat_o.empty = count_q == 2'd0;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sep2d_back.sv =====
// ----------------------------------------------------------------------------
// Separable 2D FIR back end
// Row and column multiply-accumulate on one shared multiplier, line stores
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sep2d_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sep2d_pkg::cfg_t       cfg_i,
  input  wire logic                  q_valid_i,
  input  wire sep2d_pkg::entry_t     q_data_i,
  output      logic                  q_pop_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [31:0]           out_value_o,
  output      logic [9:0]            out_x_o,
  output      logic [11:0]           out_y_o,
  output      logic                  out_sat_o,
  output      sep2d_pkg::back_stat_t stat_o
);

  sep2d_pkg::back_state_e state_q, state_d;
  sep2d_pkg::entry_t      ent_q;
  logic [23:0]            line_mem [sep2d_pkg::MemDepth];
  logic [23:0]            rd_q;
  logic [2:0]             k_q;
  logic [2:0]             rline_q;
  logic signed [39:0]     prod_q;
  logic signed [43:0]     acc_q;
  logic signed [23:0]     rres_q;
  logic                   sat_q;
  logic signed [23:0]     mul_a;
  logic signed [15:0]     mul_b;
  logic signed [43:0]     acc_sh;
  logic signed [23:0]     rres_d;
  logic                   rsat_d;
  logic signed [33:0]     total;
  logic [31:0]            fin_val;
  logic                   fin_sat;
  logic                   slot_free;
  logic [3:0]             start_line;
  logic [2:0]             row_sel;

  assign slot_free = !out_valid_o || out_ready_i;
  assign acc_sh    = acc_q >>> 15;
  assign row_sel   = cfg_i.rt_m1 - k_q;

  // Multiplier operands for the current tap.
  always_comb begin
    if (state_q == sep2d_pkg::BkRowMul) begin
      mul_a = {{8{ent_q.taps[row_sel][15]}}, ent_q.taps[row_sel]};
      mul_b = cfg_i.row_coef[{k_q, 4'd0} +: 16];
    end else begin
      mul_a = (k_q == cfg_i.ct_m1) ? rres_q : rd_q;
      mul_b = cfg_i.col_coef[{k_q, 4'd0} +: 16];
    end
  end

  // Row result saturation to 24 bits.
  always_comb begin
    rsat_d = 1'b0;
    if (acc_sh > 44'sd8388607) begin
      rres_d = 24'sh7FFFFF;
      rsat_d = 1'b1;
    end else if (acc_sh < -44'sd8388608) begin
      rres_d = 24'sh800000;
      rsat_d = 1'b1;
    end else begin
      rres_d = acc_sh[23:0];
    end
  end

  // Final value: optional add of the old value, saturated to 32 bits.
  always_comb begin
    total   = {{5{acc_sh[28]}}, acc_sh[28:0]} +
              (cfg_i.add_mode ? {{2{ent_q.old_value[31]}}, ent_q.old_value} : 34'sd0);
    fin_sat = 1'b0;
    if (total > 34'sd2147483647) begin
      fin_val = 32'h7FFFFFFF;
      fin_sat = 1'b1;
    end else if (total < -34'sd2147483648) begin
      fin_val = 32'h80000000;
      fin_sat = 1'b1;
    end else begin
      fin_val = total[31:0];
    end
  end

  // First line of the column window, modulo seven.
  assign start_line = ({1'b0, ent_q.line} >= {1'b0, cfg_i.ct_m1})
                    ? {1'b0, ent_q.line} - {1'b0, cfg_i.ct_m1}
                    : {1'b0, ent_q.line} + 4'd7 - {1'b0, cfg_i.ct_m1};

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      sep2d_pkg::BkIdle: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_data_i.do_row) state_d = sep2d_pkg::BkRowMul;
      end
      sep2d_pkg::BkRowMul: state_d = sep2d_pkg::BkRowAcc;
      sep2d_pkg::BkRowAcc: begin
        state_d = (k_q == cfg_i.rt_m1) ? sep2d_pkg::BkRowSat : sep2d_pkg::BkRowMul;
      end
      sep2d_pkg::BkRowSat: begin
        state_d = ent_q.do_out ? sep2d_pkg::BkColRd : sep2d_pkg::BkFin;
      end
      sep2d_pkg::BkColRd:  state_d = sep2d_pkg::BkColMul;
      sep2d_pkg::BkColMul: state_d = sep2d_pkg::BkColAcc;
      sep2d_pkg::BkColAcc: begin
        state_d = (k_q == cfg_i.ct_m1) ? sep2d_pkg::BkFin : sep2d_pkg::BkColRd;
      end
      sep2d_pkg::BkFin: begin
        if (!ent_q.do_out || slot_free) state_d = sep2d_pkg::BkIdle;
      end
      default: state_d = sep2d_pkg::BkIdle;
    endcase
  end

  assign stat_o.busy = state_q != sep2d_pkg::BkIdle;
  assign stat_o.fin  = (state_q == sep2d_pkg::BkFin) && ent_q.do_out && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sep2d_pkg::BkIdle;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (stat_o.fin) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      sep2d_pkg::BkIdle: begin
        ent_q <= q_data_i;
        k_q   <= 3'd0;
        acc_q <= '0;
      end
      sep2d_pkg::BkRowMul, sep2d_pkg::BkColMul: begin
        prod_q <= mul_a * mul_b;
      end
      sep2d_pkg::BkRowAcc: begin
        acc_q <= acc_q + {{4{prod_q[39]}}, prod_q};
        k_q   <= k_q + 3'd1;
      end
      sep2d_pkg::BkRowSat: begin
        rres_q  <= rres_d;
        sat_q   <= rsat_d;
        acc_q   <= '0;
        k_q     <= 3'd0;
        rline_q <= start_line[2:0];
      end
      sep2d_pkg::BkColRd: begin
        rd_q <= line_mem[{rline_q, ent_q.ox}];
      end
      sep2d_pkg::BkColAcc: begin
        acc_q   <= acc_q + {{4{prod_q[39]}}, prod_q};
        k_q     <= k_q + 3'd1;
        rline_q <= (rline_q == 3'd6) ? 3'd0 : rline_q + 3'd1;
      end
      sep2d_pkg::BkFin: begin
        if (!ent_q.do_out || slot_free) begin
          line_mem[{ent_q.line, ent_q.ox}] <= rres_q;
        end
        if (stat_o.fin) begin
          out_value_o <= fin_val;
          out_x_o     <= ent_q.ox;
          out_y_o     <= ent_q.oy;
          out_sat_o   <= sat_q || fin_sat;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/separable_2d_fir_filter_core.sv =====
// ----------------------------------------------------------------------------
// Separable 2D FIR filter core
// Valid-region separable 2D FIR over a raster sample stream.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: sample, old_value; tuser: frame_start
// m_axis    out        tdata: filtered_value, out_x, out_y; tuser: saturated
// apb       in/out     eight 64-bit registers at byte address 8*i
//
// One shared 24x16 multiplier does all taps: a sample with no row result only
// passes idle; a row result takes multiply and accumulate per row tap, then
// saturate; an output adds column read, multiply and accumulate per column tap.
// A two-entry request queue lets the front accept while the back works.
// The line stores hold no reset; entries become defined as rows are written.
// Reset clears position, sample window, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_2d_fir_filter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // sample[15:0], old_value[47:16]
  input  wire logic        s_axis_tuser,   // frame_start
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [55:0] m_axis_tdata,   // filtered_value[31:0], out_x[41:32],
                                           // out_y[53:42], zero[55:54]
  output      logic        m_axis_tuser,   // saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output      logic [63:0] prdata,
  output      logic        pready
);

  logic [10:0]  image_width_q;
  logic [3:0]   row_taps_q;
  logic [3:0]   col_taps_q;
  logic         add_mode_q;
  logic [63:0]  row_coef_lo_q, row_coef_hi_q, col_coef_lo_q, col_coef_hi_q;
  logic         cfg_wr;
  sep2d_pkg::reg_idx_e   reg_idx;
  sep2d_pkg::cfg_t       cfg;
  sep2d_pkg::entry_t     f_entry, q_entry;
  sep2d_pkg::q_stat_t    q_stat;
  sep2d_pkg::back_stat_t b_stat;
  logic         in_acc;
  logic         q_pop;
  logic [31:0]  out_value;
  logic [9:0]   out_x;
  logic [11:0]  out_y;
  logic         out_sat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = sep2d_pkg::reg_idx_e'(paddr[5:3]);

  // Register file writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= 11'd1024;
      row_taps_q    <= 4'd1;
      col_taps_q    <= 4'd1;
      add_mode_q    <= 1'b0;
      row_coef_lo_q <= '0;
      row_coef_hi_q <= '0;
      col_coef_lo_q <= '0;
      col_coef_hi_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        sep2d_pkg::RegImageWidth: image_width_q <= pwdata[10:0];
        sep2d_pkg::RegRowTaps:    row_taps_q    <= pwdata[3:0];
        sep2d_pkg::RegColTaps:    col_taps_q    <= pwdata[3:0];
        sep2d_pkg::RegAddMode:    add_mode_q    <= pwdata[0];
        sep2d_pkg::RegRowCoefLo:  row_coef_lo_q <= pwdata;
        sep2d_pkg::RegRowCoefHi:  row_coef_hi_q <= pwdata;
        sep2d_pkg::RegColCoefLo:  col_coef_lo_q <= pwdata;
        sep2d_pkg::RegColCoefHi:  col_coef_hi_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      sep2d_pkg::RegImageWidth: prdata = {53'd0, image_width_q};
      sep2d_pkg::RegRowTaps:    prdata = {60'd0, row_taps_q};
      sep2d_pkg::RegColTaps:    prdata = {60'd0, col_taps_q};
      sep2d_pkg::RegAddMode:    prdata = {63'd0, add_mode_q};
      sep2d_pkg::RegRowCoefLo:  prdata = row_coef_lo_q;
      sep2d_pkg::RegRowCoefHi:  prdata = row_coef_hi_q;
      sep2d_pkg::RegColCoefLo:  prdata = col_coef_lo_q;
      sep2d_pkg::RegColCoefHi:  prdata = col_coef_hi_q;
      default:                  prdata = '0;
    endcase
  end

  // Clamp taps to 1..8 and width to 1..1024 for the datapath.
  always_comb begin
    if (row_taps_q == 4'd0)      cfg.rt_m1 = 3'd0;
    else if (row_taps_q > 4'd8)  cfg.rt_m1 = 3'd7;
    else                         cfg.rt_m1 = 3'(row_taps_q - 4'd1);
    if (col_taps_q == 4'd0)      cfg.ct_m1 = 3'd0;
    else if (col_taps_q > 4'd8)  cfg.ct_m1 = 3'd7;
    else                         cfg.ct_m1 = 3'(col_taps_q - 4'd1);
    if (image_width_q == 11'd0)       cfg.width = 11'd1;
    else if (image_width_q > 11'd1024) cfg.width = 11'd1024;
    else                              cfg.width = image_width_q;
    cfg.add_mode = add_mode_q;
    cfg.row_coef = {row_coef_hi_q, row_coef_lo_q};
    cfg.col_coef = {col_coef_hi_q, col_coef_lo_q};
  end

  assign s_axis_tready = !q_stat.full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  sep2d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .acc_i         (in_acc),
    .sample_i      (s_axis_tdata[15:0]),
    .old_value_i   (s_axis_tdata[47:16]),
    .frame_start_i (s_axis_tuser),
    .entry_o       (f_entry)
  );

  sep2d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (f_entry),
    .pop_i       (q_pop),
    .pop_data_o  (q_entry),
    .stat_o      (q_stat)
  );

  sep2d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (!q_stat.empty),
    .q_data_i    (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_sat_o   (out_sat),
    .stat_o      (b_stat)
  );

  assign m_axis_tdata = {2'b00, out_y, out_x, out_value};
  assign m_axis_tuser = out_sat;

  // The queue never takes a request while full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !q_stat.full)
    else $error("request pushed into a full queue");

  // The queue is never popped while empty.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("request popped from an empty queue");

  // A new result appears only after the back end finished an output item.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(b_stat.fin))
    else $error("result raised without a finished item");

endmodule

`default_nettype wire

// ===== tb/sv/sep2d_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Separable 2D FIR checker
// Watches the sample, result and register channels of the filter core. It
// keeps its own copy of the registers, the sample window and the row-result
// line stores, predicts every filtered output, and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sep2d_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // sample[15:0], old_value[47:16]
  input  wire logic        s_axis_tuser,   // frame_start
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [55:0] m_axis_tdata,   // filtered_value[31:0], out_x[41:32],
                                           // out_y[53:42], zero[55:54]
  input  wire logic        m_axis_tuser,   // saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        pready,
  output int               failures_o,
  output int               pending_o
);

  typedef struct {
    logic [31:0] value;
    logic [9:0]  col;
    logic [11:0] row;
    logic        sat;
  } filt_out_t;

  // Register copy.
  logic [10:0]  width_q;
  logic [3:0]   row_taps_q;
  logic [3:0]   col_taps_q;
  logic         add_q;
  logic [127:0] row_coef_q;
  logic [127:0] col_coef_q;

  // Datapath state copy.
  logic signed [15:0] window_q [sep2d_pkg::NumLines];
  logic signed [23:0] lines_q  [sep2d_pkg::NumLines][sep2d_pkg::MaxWidth];
  int unsigned        col_pos_q;
  int unsigned        row_pos_q;

  filt_out_t expected_q[$];

  function automatic longint tap_coef(input logic [127:0] c, input int unsigned i);
    return longint'($signed(c[16*i +: 16]));
  endfunction

  function automatic int unsigned taps_in_use(input logic [3:0] t);
    if (t == 0) return 1;
    return (t > sep2d_pkg::MaxTaps) ? sep2d_pkg::MaxTaps : t;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    failures_o++;
  endtask

  // Runs one sample through the filter and queues the output it makes.
  task automatic filter_sample(input logic [15:0] smp, input logic [31:0] old,
                               input logic fs);
    int unsigned rt, ct, w, x, y, ox, i;
    longint      acc, rres, cacc, total, v;
    logic        sat;
    filt_out_t   res;
    rt  = taps_in_use(row_taps_q);
    ct  = taps_in_use(col_taps_q);
    w   = (width_q == 0) ? 1 :
          ((width_q > sep2d_pkg::MaxWidth) ? sep2d_pkg::MaxWidth : width_q);
    sat = 1'b0;
    if (fs) begin
      col_pos_q = 0;
      row_pos_q = 0;
    end
    x = col_pos_q;
    y = row_pos_q;
    if (x >= rt - 1) begin
      ox  = x - (rt - 1);
      acc = 0;
      for (i = 0; i < rt; i++) begin
        v = (i == rt - 1) ? longint'($signed(smp)) : longint'(window_q[rt - 2 - i]);
        acc += v * tap_coef(row_coef_q, i);
      end
      rres = acc >>> 15;
      if (rres > 64'sd8388607) begin rres = 8388607; sat = 1'b1; end
      if (rres < -64'sd8388608) begin rres = -8388608; sat = 1'b1; end
      if (y >= ct - 1) begin
        cacc = 0;
        for (i = 0; i < ct; i++) begin
          v = (i == ct - 1) ? rres :
              longint'(lines_q[(y - (ct - 1 - i)) % sep2d_pkg::NumLines][ox]);
          cacc += v * tap_coef(col_coef_q, i);
        end
        total = cacc >>> 15;
        if (add_q) total += longint'($signed(old));
        if (total > 64'sd2147483647) begin total = 2147483647; sat = 1'b1; end
        if (total < -64'sd2147483648) begin total = -2147483648; sat = 1'b1; end
        res.value = total[31:0];
        res.col   = ox[9:0];
        res.row   = 12'(y - (ct - 1));
        res.sat   = sat;
        expected_q.push_back(res);
      end
      lines_q[y % sep2d_pkg::NumLines][ox] = rres[23:0];
    end
    for (i = sep2d_pkg::NumLines - 1; i > 0; i--) window_q[i] = window_q[i - 1];
    window_q[0] = smp;
    if (x + 1 >= w) begin
      col_pos_q = 0;
      row_pos_q = (y + 1) & 12'hFFF;
    end else begin
      col_pos_q = x + 1;
    end
  endtask

  // Track register writes, predict on each sample request, check results.
  always @(posedge clk_i or negedge rst_ni) begin
    filt_out_t want;
    if (!rst_ni) begin
      width_q    = 11'd1024;
      row_taps_q = 4'd1;
      col_taps_q = 4'd1;
      add_q      = 1'b0;
      row_coef_q = '0;
      col_coef_q = '0;
      foreach (window_q[i]) window_q[i] = '0;
      col_pos_q  = 0;
      row_pos_q  = 0;
      expected_q.delete();
      failures_o = 0;
      pending_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (sep2d_pkg::reg_idx_e'(paddr[5:3]))
          sep2d_pkg::RegImageWidth: width_q = pwdata[10:0];
          sep2d_pkg::RegRowTaps:    row_taps_q = pwdata[3:0];
          sep2d_pkg::RegColTaps:    col_taps_q = pwdata[3:0];
          sep2d_pkg::RegAddMode:    add_q = pwdata[0];
          sep2d_pkg::RegRowCoefLo:  row_coef_q[63:0] = pwdata;
          sep2d_pkg::RegRowCoefHi:  row_coef_q[127:64] = pwdata;
          sep2d_pkg::RegColCoefLo:  col_coef_q[63:0] = pwdata;
          sep2d_pkg::RegColCoefHi:  col_coef_q[127:64] = pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        filter_sample(s_axis_tdata[15:0], s_axis_tdata[47:16], s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[31:0] !== want.value)
            report_mismatch("filtered_value", m_axis_tdata[31:0], want.value);
          if (m_axis_tdata[41:32] !== want.col)
            report_mismatch("out_x", m_axis_tdata[41:32], want.col);
          if (m_axis_tdata[53:42] !== want.row)
            report_mismatch("out_y", m_axis_tdata[53:42], want.row);
          if (m_axis_tuser !== want.sat)
            report_mismatch("saturated", m_axis_tuser, want.sat);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Separable 2D FIR testbench top
// Drives raster sample streams and register settings into the filter core
// with bursty input and a stalling output, and gives the final verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // sample[15:0], old_value[47:16]
  logic        s_axis_tuser = 1'b0; // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // filtered_value[31:0], out_x[41:32], out_y[53:42]
  logic        m_axis_tuser;        // saturated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          failures;
  int          pending;

  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          stall_mode = 0;
  int unsigned stall_cnt = 0;
  int          sent = 0;

  always #10 clk_i = ~clk_i;

  separable_2d_fir_filter_core dut (.*);

  sep2d_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .failures_o(failures), .pending_o(pending)
  );

  // Output side stalls on a pattern chosen per phase.
  always @(negedge clk_i) begin
    stall_cnt++;
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      2: m_axis_tready = ((stall_cnt % 37) < 25);
      default: m_axis_tready = ($urandom_range(0, 1) != 0);
    endcase
  end

  // Register write: setup cycle then access cycle.
  task automatic write_reg(input sep2d_pkg::reg_idx_e idx, input logic [63:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_filter(input logic [10:0] w, input logic [3:0] rt, input logic [3:0] ct,
                            input logic add, input logic [127:0] rc, input logic [127:0] cc);
    write_reg(sep2d_pkg::RegImageWidth, 64'(w));
    write_reg(sep2d_pkg::RegRowTaps, 64'(rt));
    write_reg(sep2d_pkg::RegColTaps, 64'(ct));
    write_reg(sep2d_pkg::RegAddMode, 64'(add));
    write_reg(sep2d_pkg::RegRowCoefLo, rc[63:0]);
    write_reg(sep2d_pkg::RegRowCoefHi, rc[127:64]);
    write_reg(sep2d_pkg::RegColCoefLo, cc[63:0]);
    write_reg(sep2d_pkg::RegColCoefHi, cc[127:64]);
  endtask

  // Sends one sample request and returns at the falling edge after acceptance.
  task automatic send_sample(input logic [15:0] smp, input logic [31:0] old, input logic fs);
    logic rdy;
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tdata  = {old, smp};
    s_axis_tuser  = fs;
    s_axis_tvalid = 1'b1;
    do begin
      #1 rdy = s_axis_tready;
      @(negedge clk_i);
    end while (!rdy);
    burst_left--;
    sent++;
  endtask

  // Block is idle: all results in, then room for work that makes none.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // A stretch of samples; random content with occasional extremes and restarts.
  task automatic stream(input int n, input bit first_fs);
    logic [15:0] smp;
    logic [31:0] old;
    logic        fs;
    for (int k = 0; k < n; k++) begin
      smp = 16'($urandom);
      old = $urandom;
      if ($urandom_range(0, 7) == 0) smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      if ($urandom_range(0, 5) == 0) old = $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0010;
      fs = (k == 0 && first_fs) || ($urandom_range(0, 299) == 0);
      send_sample(smp, old, fs);
    end
  endtask

  function automatic logic [127:0] rand_coefs();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    int w, rt, ct, n;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: one-tap filters with zero coefficients.
    send_sample(16'h7FFF, 32'h7FFF_FFFF, 1'b1);
    send_sample(16'h8000, 32'h8000_0000, 1'b0);
    send_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // Extreme coefficients and old values: output clips in add mode.
    stall_mode = 1;
    set_filter(11'd3, 4'd2, 4'd2, 1'b1, {112'h0, 16'h7FFF}, {96'h0, 32'h7FFF_7FFF});
    send_sample(16'h7FFF, 32'h0, 1'b1);
    send_sample(16'h7FFF, 32'h0, 1'b0);
    send_sample(16'h8000, 32'h0, 1'b0);
    send_sample(16'h7FFF, 32'h0, 1'b0);
    send_sample(16'h7FFF, 32'h7FFF_FFFF, 1'b0);
    send_sample(16'h8000, 32'h8000_0000, 1'b0);
    send_sample(16'h8000, 32'h8000_0000, 1'b0);
    send_sample(16'h7FFF, 32'h7FFF_FFFF, 1'b0);
    wait_idle();

    // Width zero counts as one; zero row taps count as one, column taps above max as max.
    set_filter(11'd0, 4'd0, 4'd15, 1'b0, rand_coefs(),
               {16'h8000, 112'h7FFF_8000_7FFF_8000_7FFF_8000_7FFF});
    stream(9, 1'b1);
    wait_idle();

    // Width above max counts as max; row taps above max count as max.
    stall_mode = 2;
    set_filter(11'd2000, 4'd9, 4'd1, 1'b1,
               {16'h8000, 112'h7FFF_8000_7FFF_8000_7FFF_8000_7FFF}, rand_coefs());
    stream(10, 1'b1);
    wait_idle();

    // Row narrower than the taps makes nothing.
    set_filter(11'd2, 4'd5, 4'd1, 1'b0, rand_coefs(), rand_coefs());
    stream(3, 1'b1);
    wait_idle();

    // Width shrinks mid-row: the row now ends at the new width.
    set_filter(11'd6, 4'd2, 4'd1, 1'b0, rand_coefs(), rand_coefs());
    stream(7, 1'b1);
    wait_idle();
    write_reg(sep2d_pkg::RegImageWidth, 64'd3);
    stream(4, 1'b0);
    wait_idle();

    // Random frames with random settings.
    while (sent < 1900) begin
      if ($urandom_range(0, 9) == 0) begin
        w  = $urandom_range(17, 300);
        ct = $urandom_range(1, 2);
      end else begin
        w  = $urandom_range(1, 16);
        ct = $urandom_range(1, 8);
      end
      rt = $urandom_range(1, 8);
      stall_mode = $urandom_range(0, 3);
      gaps_on    = ($urandom_range(0, 3) != 0);
      set_filter(11'(w), 4'(rt), 4'(ct), 1'($urandom), rand_coefs(), rand_coefs());
      n = w * (ct + $urandom_range(1, 3)) + $urandom_range(0, 5);
      if (n > 1900 - sent) n = 1900 - sent;
      stream(n, 1'b1);
      wait_idle();
    end

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
